[rtl/wbss_pkg.sv]
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types and constants for the wildcard byte signature scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbss_pkg;

   // Sizing
   localparam int MAX_PATTERN  = 32;                        // longest pattern in bytes
   localparam int OFFSET_BITS  = 32;                        // byte offset counter width
   localparam int WINDOW_DEPTH = MAX_PATTERN;               // newest bytes kept
   localparam int LEN_BITS     = $clog2(MAX_PATTERN + 1);   // holds 1..MAX_PATTERN
   localparam int ADDR_BITS    = 64;
   localparam int PAT_WORDS    = 4;                         // pattern registers
   localparam int PAT_BYTES    = PAT_WORDS * 8;
   localparam int PAT_IDX_BITS = $clog2(PAT_BYTES);
   localparam int RAW_LEN_BITS = 6;                         // pattern_length field width
   localparam int CSR_IDX_BITS = 3;

   localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

   // Result status codes
   localparam logic [1:0] STATUS_FOUND = 2'd0;
   localparam logic [1:0] STATUS_NONE  = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   // Register map
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE_ADDRESS   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd5;

   // Input transaction
   typedef struct packed {
      logic [7:0] mem_byte;
      logic       last_byte;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] match_address;
   } rsp_type;

   // Configuration view; length is already clamped to 1..MAX_PATTERN
   typedef struct packed {
      logic [ADDR_BITS-1:0]       base_address;
      logic [PAT_BYTES-1:0][7:0]  pattern;
      logic [LEN_BITS-1:0]        length;
   } cfg_type;

   // Scan stage to result stage
   typedef struct packed {
      logic [1:0]             status;
      logic [OFFSET_BITS-1:0] offset;
   } hit_type;

endpackage

`default_nettype wire

[rtl/wbss_csr.sv]
// ----------------------------------------------------------------------------
// wbss_csr
// Configuration registers: base address, pattern bytes and pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wbss_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [63:0]                       csr_wdata,
   output wbss_pkg::cfg_type                      cfg
);

   logic [wbss_pkg::ADDR_BITS-1:0]      base_ff;
   logic [wbss_pkg::PAT_BYTES-1:0][7:0] pattern_ff;
   logic [wbss_pkg::LEN_BITS-1:0]       length_ff;
   logic [wbss_pkg::LEN_BITS-1:0]       length_in;
   logic [wbss_pkg::RAW_LEN_BITS-1:0]   raw_len;
   logic                                write_en;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   // Clamp the written length to 1..MAX_PATTERN
   assign raw_len = csr_wdata[wbss_pkg::RAW_LEN_BITS-1:0];
   always_comb begin
      if (raw_len == '0) begin
         length_in = wbss_pkg::LEN_BITS'(1);
      end else if (raw_len > wbss_pkg::RAW_LEN_BITS'(wbss_pkg::MAX_PATTERN)) begin
         length_in = wbss_pkg::LEN_BITS'(wbss_pkg::MAX_PATTERN);
      end else begin
         length_in = wbss_pkg::LEN_BITS'(raw_len);
      end
   end

   // Register file; unlisted indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         pattern_ff <= '0;
         length_ff  <= wbss_pkg::LEN_BITS'(1);
      end else if (write_en) begin
         unique case (csr_index)
            wbss_pkg::REG_BASE_ADDRESS:   base_ff          <= csr_wdata;
            wbss_pkg::REG_PATTERN_WORD_0: pattern_ff[7:0]   <= csr_wdata;
            wbss_pkg::REG_PATTERN_WORD_1: pattern_ff[15:8]  <= csr_wdata;
            wbss_pkg::REG_PATTERN_WORD_2: pattern_ff[23:16] <= csr_wdata;
            wbss_pkg::REG_PATTERN_WORD_3: pattern_ff[31:24] <= csr_wdata;
            wbss_pkg::REG_PATTERN_LENGTH: length_ff         <= length_in;
            default: ;
         endcase
      end
   end

   assign cfg.base_address = base_ff;
   assign cfg.pattern      = pattern_ff;
   assign cfg.length       = length_ff;

endmodule

`default_nettype wire

[rtl/wbss_window.sv]
// ----------------------------------------------------------------------------
// wbss_window
// Byte window, offset counter and parallel wildcard compare for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_window (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wbss_pkg::req_type req_payload,
   input  wire wbss_pkg::cfg_type cfg,
   output logic                   hit_valid,
   output wbss_pkg::hit_type      hit,
   input  wire logic              hit_take
);

   logic [wbss_pkg::WINDOW_DEPTH-1:0][7:0] window_ff;
   logic [wbss_pkg::WINDOW_DEPTH-1:0][7:0] window_in;
   logic [wbss_pkg::OFFSET_BITS-1:0]       offset_ff;
   logic [wbss_pkg::OFFSET_BITS-1:0]       offset_in;
   logic                                   done_ff;
   logic                                   hit_valid_ff;
   wbss_pkg::hit_type                      hit_ff;
   wbss_pkg::hit_type                      hit_in;
   logic [wbss_pkg::WINDOW_DEPTH-1:0]      byte_ok;
   logic                                   window_hit;
   logic                                   found;
   logic                                   emit;
   logic                                   a_ready;
   logic                                   accept;

   localparam logic [wbss_pkg::OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Handshake: free slot, or the result stage drains it this cycle
   assign a_ready   = !hit_valid_ff || hit_take;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   // Window after the new byte is shifted in (index 0 is newest)
   always_comb begin
      window_in[0] = req_payload.mem_byte;
      for (int j = 1; j < wbss_pkg::WINDOW_DEPTH; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // Saturating byte count
   assign offset_in = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + 1'b1;

   // Window slot j pairs with pattern byte length-1-j
   always_comb begin
      logic [wbss_pkg::LEN_BITS-1:0] k;
      logic [7:0]                    pb;
      logic                          in_use;
      for (int j = 0; j < wbss_pkg::WINDOW_DEPTH; j++) begin
         in_use     = wbss_pkg::LEN_BITS'(j) < cfg.length;
         k          = cfg.length - wbss_pkg::LEN_BITS'(1) - wbss_pkg::LEN_BITS'(j);
         pb         = cfg.pattern[wbss_pkg::PAT_IDX_BITS'(k)];
         byte_ok[j] = !in_use || (pb == wbss_pkg::WILDCARD_BYTE) || (pb == window_in[j]);
      end
   end
   assign window_hit = &byte_ok;

   // Result decision
   assign found = (offset_in >= wbss_pkg::OFFSET_BITS'(cfg.length)) && window_hit;
   assign emit  = !done_ff && (found || req_payload.last_byte);

   always_comb begin
      hit_in.offset = offset_in;
      if (found) begin
         hit_in.status = wbss_pkg::STATUS_FOUND;
      end else if (offset_in < wbss_pkg::OFFSET_BITS'(cfg.length)) begin
         hit_in.status = wbss_pkg::STATUS_SHORT;
      end else begin
         hit_in.status = wbss_pkg::STATUS_NONE;
      end
   end

   // Search state; the last byte rearms
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         offset_ff    <= '0;
         done_ff      <= 1'b0;
         hit_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            hit_valid_ff <= accept && emit;
         end
         if (accept) begin
            if (req_payload.last_byte) begin
               window_ff <= '0;
               offset_ff <= '0;
               done_ff   <= 1'b0;
            end else if (!done_ff) begin
               window_ff <= window_in;
               offset_ff <= offset_in;
               if (found) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // Hit payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff <= hit_in;
      end
   end

   assign hit_valid = hit_valid_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

[rtl/wbss_result.sv]
// ----------------------------------------------------------------------------
// wbss_result
// Forms the match address and holds the result transaction for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_result (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              hit_valid,
   input  wire wbss_pkg::hit_type hit,
   output logic                   hit_take,
   input  wire wbss_pkg::cfg_type cfg,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wbss_pkg::rsp_type      rsp_payload
);

   logic                             rsp_valid_ff;
   wbss_pkg::rsp_type                rsp_ff;
   wbss_pkg::rsp_type                rsp_in;
   logic [wbss_pkg::OFFSET_BITS-1:0] start;
   logic                             load;

   // Output register is free or being emptied
   assign hit_take = !rsp_valid_ff || !rsp_stall;
   assign load     = hit_valid && hit_take;

   // Match start = count - length, address = base + start
   assign start = hit.offset - wbss_pkg::OFFSET_BITS'(cfg.length);

   always_comb begin
      rsp_in.status = hit.status;
      if (hit.status == wbss_pkg::STATUS_FOUND) begin
         rsp_in.match_address = cfg.base_address + wbss_pkg::ADDR_BITS'(start);
      end else begin
         rsp_in.match_address = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (hit_take) begin
         rsp_valid_ff <= hit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/wildcard_byte_signature_scan_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_unit
// Streams a memory region byte by byte and reports the first wildcard match.
// ----------------------------------------------------------------------------
// The unit takes one region byte per clock while nothing stalls and returns
// one result per search, for the byte that completes the first match or,
// failing that, for the byte flagged last_byte, via the scan and result stage
// registers. The new byte is compared against every pattern position at once
// in the scan stage, and the match address is formed in the following result
// stage. Result-side stall backs up both stages. Program the pattern and base
// address while no search is in flight; 0x2A in the pattern is a wildcard.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_signature_scan_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire wbss_pkg::req_type                 req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output wbss_pkg::rsp_type                      rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [wbss_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [63:0]                       csr_wdata
);

   wbss_pkg::cfg_type cfg;
   wbss_pkg::hit_type hit;
   logic              hit_valid;
   logic              hit_take;

   // Configuration registers
   wbss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Scan stage
   wbss_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .hit_valid   (hit_valid),
      .hit         (hit),
      .hit_take    (hit_take)
   );

   // Result stage
   wbss_result u_result (
      .clock       (clock),
      .reset       (reset),
      .hit_valid   (hit_valid),
      .hit         (hit),
      .hit_take    (hit_take),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[rtl/wbss_checker.sv]
// ----------------------------------------------------------------------------
// wbss_checker
// Port-level checks for the scan unit, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbss_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire wbss_pkg::rsp_type                 rsp_payload
);

   // Only the three defined status codes appear
   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == wbss_pkg::STATUS_FOUND ||
                     rsp_payload.status == wbss_pkg::STATUS_NONE  ||
                     rsp_payload.status == wbss_pkg::STATUS_SHORT))
      else $error("result status code out of range");

   // No match means a zero address
   a_zero_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != wbss_pkg::STATUS_FOUND)
         |-> (rsp_payload.match_address == '0))
      else $error("non-match result carries an address");

   // A stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // A fresh result is preceded by an accepted byte
   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a causing transaction");

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_checker (.*);

`default_nettype wire
